FILE: sv/qdc_pkg.sv
`timescale 1ns / 1ps

package qdc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TOTAL_WIDTH         = 32;
   localparam int PERIOD_WIDTH        = 32;
   localparam int SAMPLE_WIDTH        = 32;
   localparam logic [PERIOD_WIDTH-1:0] REPORT_PERIOD_RESET = 32'd500000;

   typedef enum logic [1:0] {
      STEP_NONE  = 2'd0,
      STEP_LEFT  = 2'd1,
      STEP_RIGHT = 2'd2,
      STEP_SKIP  = 2'd3
   } step_type;

   typedef struct packed {
      logic clock_pin;
      logic data_pin;
   } req_type;

   typedef struct packed {
      logic [1:0]             step_event;
      logic                   report_valid;
      logic [TOTAL_WIDTH-1:0] left_total;
      logic [TOTAL_WIDTH-1:0] right_total;
      logic [TOTAL_WIDTH-1:0] skip_total;
   } rsp_type;

   // input stage as seen by the decode logic
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

   // phase is clock_pin + 2*data_pin; forward gray order 0,1,3,2 counts left
   function automatic step_type step_lookup(input logic [1:0] old_phase,
                                            input logic [1:0] new_phase);
      step_type code;
      code = STEP_NONE;
      case ({old_phase, new_phase})
         4'b00_01: code = STEP_LEFT;
         4'b00_10: code = STEP_RIGHT;
         4'b00_11: code = STEP_SKIP;
         4'b01_00: code = STEP_RIGHT;
         4'b01_10: code = STEP_SKIP;
         4'b01_11: code = STEP_LEFT;
         4'b10_00: code = STEP_LEFT;
         4'b10_01: code = STEP_SKIP;
         4'b10_11: code = STEP_RIGHT;
         4'b11_00: code = STEP_SKIP;
         4'b11_01: code = STEP_RIGHT;
         4'b11_10: code = STEP_LEFT;
         default:  code = STEP_NONE;
      endcase
      return code;
   endfunction

endpackage

FILE: sv/qdc_in_reg.sv
`timescale 1ns / 1ps

module qdc_in_reg
   import qdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      advance,
   output stage_type stage
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: sv/qdc_core.sv
`timescale 1ns / 1ps

module qdc_core
   import qdc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [PERIOD_WIDTH-1:0] csr_write_data,
   input  stage_type               stage,
   input  logic                    advance,
   output rsp_type                 result
);

   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic [SAMPLE_WIDTH-1:0] sample_in;
   logic [1:0]              phase_ff;
   logic [1:0]              phase_in;
   logic [COUNT_WIDTH-1:0]  left_ff;
   logic [COUNT_WIDTH-1:0]  left_in;
   logic [COUNT_WIDTH-1:0]  right_ff;
   logic [COUNT_WIDTH-1:0]  right_in;
   logic [COUNT_WIDTH-1:0]  skip_ff;
   logic [COUNT_WIDTH-1:0]  skip_in;
   logic                    report;
   step_type                step_code;

   always_comb begin
      report    = sample_ff > period_ff;
      phase_in  = {stage.item.data_pin, stage.item.clock_pin};
      step_code = step_lookup(phase_ff, phase_in);
      left_in   = left_ff;
      right_in  = right_ff;
      skip_in   = skip_ff;
      result    = '0;
      result.step_event = step_code;
      if (report) begin
         result.report_valid = 1'b1;
         result.left_total   = TOTAL_WIDTH'(left_ff);
         result.right_total  = TOTAL_WIDTH'(right_ff);
         result.skip_total   = TOTAL_WIDTH'(skip_ff);
         left_in   = '0;
         right_in  = '0;
         sample_in = '0;
      end else begin
         sample_in = sample_ff + 1'b1;
      end
      // counts hold at all ones
      case (step_code)
         STEP_LEFT: begin
            if (!(&left_in)) left_in = left_in + 1'b1;
         end
         STEP_RIGHT: begin
            if (!(&right_in)) right_in = right_in + 1'b1;
         end
         STEP_SKIP: begin
            if (!(&skip_in)) skip_in = skip_in + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= REPORT_PERIOD_RESET;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         phase_ff  <= '0;
         left_ff   <= '0;
         right_ff  <= '0;
         skip_ff   <= '0;
      end else if (advance) begin
         sample_ff <= sample_in;
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

FILE: sv/qdc_rsp_reg.sv
`timescale 1ns / 1ps

module qdc_rsp_reg
   import qdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type result,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // slot frees up in the same cycle as its transfer
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/quadrature_direction_counter.sv
`timescale 1ns / 1ps

// channel   ports                                  moves
// -------   -------------------------------------  ------------------------------
// req       req_valid, req_ready, req_data         one pin sample per transfer
// rsp       rsp_valid, rsp_ready, rsp_data         one step result per sample
// csr       csr_write_enable, csr_write_data       report period, single cycle
//
// one sample per cycle sustained while rsp_ready is high; a sample's result goes
// through the input register, then decode and counter update into the result register.
// reset clears counters, phase and both pipeline stages; period returns to 500000.
// a stalled rsp holds the result register; req_ready drops only when both stages
// are full and rsp_ready is low.

module quadrature_direction_counter
   import qdc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_write_enable,
   input  logic [PERIOD_WIDTH-1:0] csr_write_data
);

   stage_type stage;
   rsp_type   result;
   logic      out_free;
   logic      advance;

   assign advance = stage.valid && out_free;

   qdc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .stage     (stage)
   );

   qdc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage            (stage),
      .advance          (advance),
      .result           (result)
   );

   qdc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/qdc_checker.sv
`timescale 1ns / 1ps

module qdc_checker
   import qdc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input rsp_type                 rsp_data
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // totals are only carried by a report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.report_valid |->
         rsp_data.left_total == '0 && rsp_data.right_total == '0 &&
         rsp_data.skip_total == '0)
      else $error("totals without report");

   // no back pressure unless the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req_ready low with result side free");

   // nothing comes out straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind quadrature_direction_counter qdc_checker u_qdc_checker (.*);

FILE: tb/tb_quadrature_direction_counter.sv
`timescale 1ns / 1ps

module tb_quadrature_direction_counter;
   import qdc_pkg::*;

   localparam int COUNTER_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 64;
   localparam int PHASE_ITEMS   = 190;
   localparam int PHASE_COUNT   = 8;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;

   class step_scoreboard;
      rsp_type                  expected_steps[$];
      logic [1:0]               phase;
      logic [SAMPLE_WIDTH-1:0]  sample_count;
      logic [COUNTER_WIDTH-1:0] left_count;
      logic [COUNTER_WIDTH-1:0] right_count;
      logic [COUNTER_WIDTH-1:0] skip_count;
      logic [PERIOD_WIDTH-1:0]  report_period;
      int                       failures;

      function new();
         phase         = 2'd0;
         sample_count  = '0;
         left_count    = '0;
         right_count   = '0;
         skip_count    = '0;
         report_period = REPORT_PERIOD_RESET;
         failures      = 0;
      endfunction

      function void set_period(logic [PERIOD_WIDTH-1:0] value);
         report_period = value;
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      // position along the left-going gray order 0,1,3,2
      function logic [1:0] gray_pos(logic [1:0] p);
         return {p[1], p[1] ^ p[0]};
      endfunction

      function step_type classify(logic [1:0] old_phase, logic [1:0] next_phase);
         logic [1:0] delta;
         delta = gray_pos(next_phase) - gray_pos(old_phase);
         if (delta == 2'd0) return STEP_NONE;
         if (delta == 2'd2) return STEP_SKIP;
         if (delta == 2'd1) return STEP_LEFT;
         return STEP_RIGHT;
      endfunction

      function logic [COUNTER_WIDTH-1:0] bump(logic [COUNTER_WIDTH-1:0] count);
         return (count == '1) ? count : count + 1'b1;
      endfunction

      function void note_sample(req_type sample);
         rsp_type    expect_rsp;
         logic [1:0] next_phase;
         step_type   step;
         expect_rsp = '0;
         if (sample_count > report_period) begin
            expect_rsp.report_valid = 1'b1;
            expect_rsp.left_total   = left_count[TOTAL_WIDTH-1:0];
            expect_rsp.right_total  = right_count[TOTAL_WIDTH-1:0];
            expect_rsp.skip_total   = skip_count[TOTAL_WIDTH-1:0];
            left_count   = '0;
            right_count  = '0;
            sample_count = '0;
         end else begin
            sample_count = sample_count + 1'b1;
         end
         next_phase = {sample.data_pin, sample.clock_pin};
         step       = classify(phase, next_phase);
         case (step)
            STEP_LEFT:  left_count  = bump(left_count);
            STEP_RIGHT: right_count = bump(right_count);
            STEP_SKIP:  skip_count  = bump(skip_count);
            default:    ;
         endcase
         phase = next_phase;
         expect_rsp.step_event = step;
         expected_steps.push_back(expect_rsp);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_steps.size() == 0) begin
            $error("unexpected result: step_event %0d report_valid %0d",
                   got.step_event, got.report_valid);
            failures++;
            return;
         end
         want = expected_steps.pop_front();
         compare_field("step_event", 32'(want.step_event), 32'(got.step_event));
         compare_field("report_valid", 32'(want.report_valid), 32'(got.report_valid));
         compare_field("left_total", want.left_total, got.left_total);
         compare_field("right_total", want.right_total, got.right_total);
         compare_field("skip_total", want.skip_total, got.skip_total);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    csr_write_enable;
   logic [PERIOD_WIDTH-1:0] csr_write_data;

   step_scoreboard sb;
   int             quiet_cycles = 0;
   logic           long_hold_wanted;
   logic [1:0]     walk_pos;
   logic           walk_left;
   int             walk_run;
   logic [1:0]     directed_phases [17];
   logic [PERIOD_WIDTH-1:0] phase_periods [PHASE_COUNT];

   quadrature_direction_counter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: runs of different stall densities, plus one long hold on request
   initial begin : receiver
      int mode;
      int run;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 40);
            repeat (run) begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic req_type phase_sample(logic [1:0] p);
      req_type s;
      s.clock_pin = p[0];
      s.data_pin  = p[1];
      return s;
   endfunction

   // mostly gray-code walks in one direction, with holds, reversals and skips mixed in
   function automatic req_type pick_sample();
      int roll;
      if (walk_run == 0) begin
         walk_left = 1'($urandom_range(0, 1));
         walk_run  = $urandom_range(1, 24);
      end
      walk_run--;
      roll = $urandom_range(0, 99);
      if (roll < 72) walk_pos = walk_left ? walk_pos + 2'd1 : walk_pos - 2'd1;
      else if (roll >= 84 && roll < 92) walk_pos = walk_left ? walk_pos - 2'd1 : walk_pos + 2'd1;
      else if (roll >= 92) walk_pos = 2'($urandom_range(0, 3));
      return phase_sample({walk_pos[1], walk_pos[1] ^ walk_pos[0]});
   endfunction

   task automatic send_sample(input req_type sample);
      req_valid <= 1'b1;
      req_data  <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_period(value);
   endtask

   task automatic run_phase(input int item_count, input bit no_gaps);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < item_count) begin
         burst = $urandom_range(1, 32);
         for (int k = 0; k < burst && sent < item_count; k++) begin
            send_sample(pick_sample());
            sent++;
         end
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      sb               = new();
      long_hold_wanted = 1'b0;
      walk_pos         = 2'd0;
      walk_left        = 1'b1;
      walk_run         = 0;
      // every ordered pair of phases, holds included
      directed_phases  = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                           2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // a few samples under the reset period, then reports on every other sample
      send_sample(phase_sample(2'd3));
      send_sample(phase_sample(2'd3));
      send_sample(phase_sample(2'd0));
      send_sample(phase_sample(2'd1));
      drain_results();
      write_period('0);
      foreach (directed_phases[i]) send_sample(phase_sample(directed_phases[i]));
      drain_results();
      walk_pos = 2'd0;

      phase_periods[0] = 32'd1;
      phase_periods[1] = $urandom_range(2, 40);
      phase_periods[2] = 32'd5;
      phase_periods[3] = PERIOD_MAX;
      phase_periods[4] = '0;
      phase_periods[5] = $urandom_range(50, 300);
      phase_periods[6] = PERIOD_MAX - 1'b1;
      phase_periods[7] = 32'd2;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_period(phase_periods[p]);
         // back-to-back samples against a long receiver hold fill the pipeline
         if (p == 2) long_hold_wanted = 1'b1;
         run_phase(PHASE_ITEMS, p == 2);
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/qdc_pkg.sv
sv/qdc_in_reg.sv
sv/qdc_core.sv
sv/qdc_rsp_reg.sv
sv/quadrature_direction_counter.sv
sv/qdc_checker.sv
tb/tb_quadrature_direction_counter.sv
